// ===== rtl/rlb_pkg.sv =====
// Shared types, constants and tables for the RGB layer blend block.
package rlb_pkg;

  // Q0.16 fixed point with headroom for 1.0 (65536 needs 17 bits).
  localparam int FxW = 17;
  typedef logic [FxW-1:0] fx_t;
  localparam fx_t FX_ONE = 17'h10000;

  // Blend mode register codes.
  typedef enum logic [1:0] {
    MODE_SCREEN   = 2'd0,
    MODE_MULTIPLY = 2'd1,
    MODE_SOFT     = 2'd2,
    MODE_DARKEN   = 2'd3
  } blend_mode_e;

  // Load enables for the four pipeline stages of a channel.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } stage_en_t;

  typedef fx_t sqrt_lut_t [256];

  // Rounded normalization v*65536/255: since 65535 = 255*257 this is
  // v*257 plus one when v is 128 or more.
  function automatic fx_t fx_norm(input logic [7:0] v);
    fx_norm = FxW'({v, 8'h00}) + FxW'(v) + FxW'(v[7]);
  endfunction

  // Builds round(65536*sqrt(v/255)) for every 8-bit v by a binary search
  // on the odd numbers; evaluated only at elaboration.
  function automatic sqrt_lut_t build_sqrt_lut();
    sqrt_lut_t        lut;
    longint unsigned  target;
    longint unsigned  lo;
    longint unsigned  hi;
    longint unsigned  mid;
    longint unsigned  odd;
    for (int v = 0; v < 256; v++) begin
      target = longint'(v) << 34;
      lo = 0;
      hi = 65536;
      for (int i = 0; i < 20; i++) begin
        if (lo < hi) begin
          mid = (lo + hi + 1) >> 1;
          odd = 2 * mid - 1;
          if (255 * odd * odd <= target) begin
            lo = mid;
          end else begin
            hi = mid - 1;
          end
        end
      end
      lut[v] = FxW'(lo);
    end
    return lut;
  endfunction

  localparam sqrt_lut_t SQRT_LUT = build_sqrt_lut();

endpackage

// ===== rtl/rlb_in_if.sv =====
// Input channel: one base pixel and one blend pixel per word.
interface rlb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] base_red;
  logic [7:0] base_green;
  logic [7:0] base_blue;
  logic [7:0] top_red;
  logic [7:0] top_green;
  logic [7:0] top_blue;

  modport source (
    output valid, base_red, base_green, base_blue, top_red, top_green, top_blue,
    input  ready
  );
  modport sink (
    input  valid, base_red, base_green, base_blue, top_red, top_green, top_blue,
    output ready
  );
endinterface

// ===== rtl/rlb_out_if.sv =====
// Output channel: one blended pixel per word.
interface rlb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;

  modport source (
    output valid, out_red, out_green, out_blue,
    input  ready
  );
  modport sink (
    input  valid, out_red, out_green, out_blue,
    output ready
  );
endinterface

// ===== rtl/rlb_channel.sv =====
// Four-stage blend datapath for one color channel.
module rlb_channel
  import rlb_pkg::*;
(
  input  logic        clk_i,
  input  stage_en_t   en_i,
  input  blend_mode_e mode_i,
  input  logic [7:0]  base_i,
  input  logic [7:0]  top_i,
  output logic [7:0]  result_o
);

  // Stage 1: normalize, look up the square root and pick multiplier operands.
  fx_t               a;
  fx_t               b;
  fx_t               s;
  logic              lower;
  logic [FxW:0]      b2;
  fx_t               m1_d, m2_d, q1_d, q2_d, c_d;
  fx_t               m1_q, m2_q, q1_q, q2_q, c_q;
  blend_mode_e       mode1_q;
  logic [7:0]        min1_q;

  assign a     = fx_norm(base_i);
  assign b     = fx_norm(top_i);
  assign s     = SQRT_LUT[base_i];
  assign lower = ~top_i[7];
  assign b2    = {b, 1'b0};

  always_comb begin
    q1_d = lower ? a : s;
    q2_d = lower ? a : FX_ONE;
    c_d  = lower ? FxW'({1'b0, FX_ONE} - b2) : FxW'(b2 - {1'b0, FX_ONE});
    unique case (mode_i)
      MODE_SCREEN: begin
        m1_d = FX_ONE - a;
        m2_d = FX_ONE - b;
      end
      MODE_SOFT: begin
        m1_d = a;
        m2_d = lower ? b : FX_ONE - b;
      end
      default: begin
        m1_d = a;
        m2_d = b;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      m1_q    <= m1_d;
      m2_q    <= m2_d;
      q1_q    <= q1_d;
      q2_q    <= q2_d;
      c_q     <= c_d;
      mode1_q <= mode_i;
      min1_q  <= (base_i < top_i) ? base_i : top_i;
    end
  end

  // Stage 2: main product and the squared (or square root) term.
  logic [2*FxW-1:0] prod_p;
  logic [2*FxW-1:0] prod_x;
  fx_t              p2_q, x2_q, c2_q;
  blend_mode_e      mode2_q;
  logic [7:0]       min2_q;

  assign prod_p = (2*FxW)'(m1_q) * (2*FxW)'(m2_q);
  assign prod_x = (2*FxW)'(q1_q) * (2*FxW)'(q2_q);

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      p2_q    <= prod_p[FxW+15:16];
      x2_q    <= prod_x[FxW+15:16];
      c2_q    <= c_q;
      mode2_q <= mode1_q;
      min2_q  <= min1_q;
    end
  end

  // Stage 3: scale the second soft light term by its coefficient.
  logic [2*FxW-1:0] prod_y;
  fx_t              p3_q, y3_q;
  blend_mode_e      mode3_q;
  logic [7:0]       min3_q;

  assign prod_y = (2*FxW)'(x2_q) * (2*FxW)'(c2_q);

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      p3_q    <= p2_q;
      y3_q    <= prod_y[FxW+15:16];
      mode3_q <= mode2_q;
      min3_q  <= min2_q;
    end
  end

  // Stage 4: combine per mode, scale by 255, truncate and clamp.
  logic [FxW:0]     r;
  logic [FxW+8:0]   scaled;
  logic [9:0]       whole;
  logic [7:0]       res_d;
  logic [7:0]       res_q;

  always_comb begin
    unique case (mode3_q)
      MODE_SCREEN:   r = {1'b0, FX_ONE - p3_q};
      MODE_MULTIPLY: r = {1'b0, p3_q};
      default:       r = {p3_q, 1'b0} + {1'b0, y3_q};
    endcase
    scaled = {r, 8'h00} - (FxW+9)'(r);
    whole  = scaled[FxW+8:16];
    if (mode3_q == MODE_DARKEN) begin
      res_d = min3_q;
    end else if (whole > 10'd255) begin
      res_d = 8'hFF;
    end else begin
      res_d = whole[7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s4) begin
      res_q <= res_d;
    end
  end

  assign result_o = res_q;

endmodule

// ===== rtl/rgb_layer_blend.sv =====
// Top level of the RGB layer blend block: mode register and stage control.
//
// pix_in_i carries one word per pixel pair: a base pixel and a blend pixel,
// 8 bits per color. pix_out_o carries one blended pixel per word, in order.
// Both use valid/ready; a word moves on a clock edge with both high.
// The 2-bit mode (screen, multiply, soft light, darken) is written through
// cfg_we_i / cfg_wdata_i and should change only while the pipeline is empty.
//
// Each word passes stages one to four, all registered. Throughput is one
// pixel per cycle while the output is ready; each color runs through its own
// four-stage datapath with one multiplier per operand pair in stages two and
// three. When the receiver stalls, each stage holds its word until the stage
// after it has room, so bubbles are squeezed out and nothing is lost or
// repeated; pix_in_i.ready drops once every stage is full.
//
// Reset clears all stage valid bits and sets the mode to screen.
module rgb_layer_blend
  import rlb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_wdata_i,
  rlb_in_if.sink     pix_in_i,
  rlb_out_if.source  pix_out_o
);

  // Mode register.
  blend_mode_e mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_SCREEN;
    end else if (cfg_we_i) begin
      mode_q <= blend_mode_e'(cfg_wdata_i);
    end
  end

  // Stage valid bits; a stage loads when it is empty or the next one moves.
  logic [3:0] valid_q;
  stage_en_t  en;

  assign en.s4 = ~valid_q[3] | pix_out_o.ready;
  assign en.s3 = ~valid_q[2] | en.s4;
  assign en.s2 = ~valid_q[1] | en.s3;
  assign en.s1 = ~valid_q[0] | en.s2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en.s1) valid_q[0] <= pix_in_i.valid;
      if (en.s2) valid_q[1] <= valid_q[0];
      if (en.s3) valid_q[2] <= valid_q[1];
      if (en.s4) valid_q[3] <= valid_q[2];
    end
  end

  assign pix_in_i.ready  = en.s1;
  assign pix_out_o.valid = valid_q[3];

  // One datapath per color.
  rlb_channel u_red (
    .clk_i    (clk_i),
    .en_i     (en),
    .mode_i   (mode_q),
    .base_i   (pix_in_i.base_red),
    .top_i    (pix_in_i.top_red),
    .result_o (pix_out_o.out_red)
  );

  rlb_channel u_green (
    .clk_i    (clk_i),
    .en_i     (en),
    .mode_i   (mode_q),
    .base_i   (pix_in_i.base_green),
    .top_i    (pix_in_i.top_green),
    .result_o (pix_out_o.out_green)
  );

  rlb_channel u_blue (
    .clk_i    (clk_i),
    .en_i     (en),
    .mode_i   (mode_q),
    .base_i   (pix_in_i.base_blue),
    .top_i    (pix_in_i.top_blue),
    .result_o (pix_out_o.out_blue)
  );

endmodule
